// ===== sv/sfpm_pkg.sv =====
package sfpm_pkg;

  localparam int DATA_W  = 64;
  localparam int DIGIT_W = 16;
  localparam int FRAC_W  = 7;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 7'd32;

  typedef struct packed {
    logic valid;
    logic neg;
  } cell_ctl_t;

endpackage

// ===== sv/sfpm_cell.sv =====
module sfpm_cell #(
  parameter int OPERAND_WIDTH = 64,
  parameter int B_W           = 64,
  parameter int IDX           = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfpm_pkg::cell_ctl_t          ctl_in,
  input  logic [OPERAND_WIDTH-1:0]     a_in,
  input  logic [B_W-1:0]               b_in,
  input  logic [2*OPERAND_WIDTH-1:0]   acc_in,
  output logic                         ready_in,
  input  logic                         ready_out,
  output sfpm_pkg::cell_ctl_t          ctl_out,
  output logic [OPERAND_WIDTH-1:0]     a_out,
  output logic [B_W-1:0]               b_out,
  output logic [2*OPERAND_WIDTH-1:0]   acc_out
);
  import sfpm_pkg::*;

  localparam int SHIFT = IDX * DIGIT_W;
  localparam int ACC_W = 2 * OPERAND_WIDTH;

  cell_ctl_t                         ctl_r;
  logic [OPERAND_WIDTH-1:0]          a_r;
  logic [B_W-1:0]                    b_r;
  logic [ACC_W-1:0]                  acc_r;
  logic [ACC_W-1:0]                  acc_nxt;
  logic [OPERAND_WIDTH+DIGIT_W-1:0]  part;

  assign ready_in = !ctl_r.valid || ready_out;

  // one 16-bit digit of the multiplier per cell
  assign part    = a_in * b_in[SHIFT +: DIGIT_W];
  assign acc_nxt = acc_in + (ACC_W'(part) << SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_in) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      a_r   <= a_in;
      b_r   <= b_in;
      acc_r <= acc_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign a_out   = a_r;
  assign b_out   = b_r;
  assign acc_out = acc_r;

endmodule

// ===== sv/signed_fixed_point_multiply_shift_unit.sv =====
// Signed fixed-point multiply with a programmable fraction shift.
// Input channel: in_multiplicand and in_multiplier, taken when in_valid is
// high and in_stall is low. Result channel: out_product, delivered when
// out_valid is high and out_stall is low. cfg_wr_en writes cfg_wr_data
// into the fraction shift; write it only while no request is in flight.
// The magnitudes are multiplied in a row of cells, one 16-bit digit of the
// multiplier per cell, then shifted right by frac_bits, wrapped to
// OPERAND_WIDTH bits, negated when the signs differ and sign-extended.
// The input stage takes the request at the accepting edge; it then passes
// through one register per cell, the shift stage and the output register.
// Throughput: one request per cycle while out_stall is low.
// Each stage holds its request while the next one is full, so a stalled
// output keeps accepting input until every stage is occupied; bubbles
// in the row are filled. Reset empties all stages and sets frac_bits
// to 32.
module signed_fixed_point_multiply_shift_unit #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sfpm_pkg::DATA_W-1:0]    in_multiplicand,
  input  logic signed [sfpm_pkg::DATA_W-1:0]    in_multiplier,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sfpm_pkg::DATA_W-1:0]   out_product,
  input  logic                                  cfg_wr_en,
  input  logic [sfpm_pkg::FRAC_W-1:0]           cfg_wr_data
);
  import sfpm_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int NCELL = (OPERAND_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int B_W   = NCELL * DIGIT_W;
  localparam int ACC_W = 2 * OPERAND_WIDTH;

  logic [FRAC_W-1:0] frac_r;

  // input stage
  cell_ctl_t         in_ctl_r;
  logic [W-1:0]      a_mag_r;
  logic [B_W-1:0]    b_mag_r;
  logic [W-1:0]      x, y, x_mag, y_mag;
  logic              rdy_in_stage;

  // cell row links
  cell_ctl_t         ctl_w [NCELL+1];
  logic [W-1:0]      a_w   [NCELL+1];
  logic [B_W-1:0]    b_w   [NCELL+1];
  logic [ACC_W-1:0]  acc_w [NCELL+1];
  logic              rdy_w [NCELL+1];

  // shift and output stages
  cell_ctl_t         sh_ctl_r;
  logic [W-1:0]      sh_r;
  logic              rdy_sh;
  logic              rdy_out;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_product_r;
  logic [W-1:0]      res_signed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else if (cfg_wr_en) begin
      frac_r <= cfg_wr_data;
    end
  end

  assign x     = in_multiplicand[W-1:0];
  assign y     = in_multiplier[W-1:0];
  assign x_mag = x[W-1] ? (W)'(-x) : x;
  assign y_mag = y[W-1] ? (W)'(-y) : y;

  assign rdy_in_stage = !in_ctl_r.valid || rdy_w[0];
  assign in_stall     = !rdy_in_stage;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else if (rdy_in_stage) begin
      in_ctl_r.valid <= in_valid;
      in_ctl_r.neg   <= x[W-1] ^ y[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in_stage) begin
      a_mag_r <= x_mag;
      b_mag_r <= B_W'(y_mag);
    end
  end

  assign ctl_w[0] = in_ctl_r;
  assign a_w[0]   = a_mag_r;
  assign b_w[0]   = b_mag_r;
  assign acc_w[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sfpm_cell #(
      .OPERAND_WIDTH(W),
      .B_W          (B_W),
      .IDX          (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl_w[k]),
      .a_in     (a_w[k]),
      .b_in     (b_w[k]),
      .acc_in   (acc_w[k]),
      .ready_in (rdy_w[k]),
      .ready_out(rdy_w[k+1]),
      .ctl_out  (ctl_w[k+1]),
      .a_out    (a_w[k+1]),
      .b_out    (b_w[k+1]),
      .acc_out  (acc_w[k+1])
    );
  end

  assign rdy_w[NCELL] = rdy_sh;
  assign rdy_sh       = !sh_ctl_r.valid || rdy_out;

  // shift of the whole product or more yields zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_ctl_r <= '0;
    end else if (rdy_sh) begin
      sh_ctl_r <= ctl_w[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_sh) begin
      sh_r <= W'(acc_w[NCELL] >> frac_r);
    end
  end

  assign rdy_out    = !out_valid_r || !out_stall;
  assign res_signed = sh_ctl_r.neg ? (W)'(-sh_r) : sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= sh_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_product_r <= DATA_W'($signed(res_signed));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;

  a_empty_out_accepts : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while output register empty");

  a_shift_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (sh_ctl_r.valid && rdy_out) |=> out_valid_r)
    else $error("shift stage request lost");

  a_full_shift_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (int'(frac_r) >= ACC_W)) |-> (out_product_r == '0))
    else $error("nonzero product with shift beyond product width");

  a_sign_ext : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_product_r == DATA_W'($signed(out_product_r[W-1:0]))))
    else $error("product not sign-extended");

endmodule

// ===== sim/tb_signed_fixed_point_multiply_shift_unit.sv =====
`timescale 1ns / 100ps

module tb_signed_fixed_point_multiply_shift_unit;

  import sfpm_pkg::*;

  localparam int OPW = 64;

  localparam logic [63:0] MAX_S   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_S   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] ALT_A   = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT_5   = 64'h5555_5555_5555_5555;

  typedef struct {
    logic [DATA_W-1:0] mcand;
    logic [DATA_W-1:0] mplier;
  } operand_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_W-1:0] in_multiplicand = '0;
  logic signed [DATA_W-1:0] in_multiplier = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_product;
  logic cfg_wr_en = 1'b0;
  logic [FRAC_W-1:0] cfg_wr_data = '0;

  operand_pair_t operand_fifo[$];
  logic [DATA_W-1:0] expected_products[$];
  logic [FRAC_W-1:0] frac_model = FRAC_RESET;

  int queued_count = 0;
  int done_count = 0;
  int mismatches = 0;
  bit in_taken = 1'b0;
  bit gaps_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  signed_fixed_point_multiply_shift_unit #(
    .OPERAND_WIDTH(OPW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_multiplicand(in_multiplicand),
    .in_multiplier(in_multiplier),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_product(out_product),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // magnitude product, shift, wrap to OPW bits, then restore sign (truncates toward zero)
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [FRAC_W-1:0] shift);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [127:0] full;
    logic neg;
    mask = ALL_ONE >> (64 - OPW);
    x = a & mask;
    y = b & mask;
    neg = 1'b0;
    if (x[OPW-1]) begin
      neg = ~neg;
      x = (-x) & mask;
    end
    if (y[OPW-1]) begin
      neg = ~neg;
      y = (-y) & mask;
    end
    full = {64'd0, x} * {64'd0, y};
    if (shift >= 2 * OPW) r = '0;
    else r = 64'(full >> shift);
    r &= mask;
    if (neg) r = (-r) & mask;
    if (r[OPW-1]) r |= ~mask;
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: v = MAX_S;
          1: v = MIN_S;
          2: v = '0;
          3: v = 64'd1;
          4: v = ALL_ONE;
          5: v = ONE_Q32;
          default: v = -ONE_Q32;
        endcase
      end
      1, 2: v = 64'($signed(32'($urandom)));
      3: v = 64'($signed(32'($urandom))) <<< $urandom_range(0, 31);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_pair(input logic [63:0] a, input logic [63:0] b);
    operand_fifo.push_back('{a, b});
    queued_count++;
  endtask

  task automatic wait_drained();
    while (done_count != queued_count) @(negedge clk);
  endtask

  task automatic run_phase(input int n, input logic [FRAC_W-1:0] frac, input bit gaps);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= frac;
    frac_model = frac;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    gaps_on = gaps;
    repeat (n) queue_pair(rand_operand(), rand_operand());
  endtask

  // request driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
        in_multiplicand <= {$urandom, $urandom};
        in_multiplier <= {$urandom, $urandom};
      end else if (operand_fifo.size() > 0) begin
        operand_pair_t req;
        req = operand_fifo.pop_front();
        in_valid <= 1'b1;
        in_multiplicand <= req.mcand;
        in_multiplier <= req.mplier;
        if (gaps_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
        in_multiplicand <= {$urandom, $urandom};
        in_multiplier <= {$urandom, $urandom};
      end
    end
  end

  // one long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (!long_hold_done && done_count >= 300) begin
      hold_left = 60;
      long_hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // result receiver: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [63:0] want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      expected_products.push_back(scaled_product(in_multiplicand, in_multiplier, frac_model));
    if (rst_n && out_valid && !out_stall) begin
      done_count++;
      if (expected_products.size() == 0) begin
        report_mismatch($sformatf("unexpected product %h", out_product));
      end else begin
        want = expected_products.pop_front();
        if (out_product !== want)
          report_mismatch($sformatf("product got %h want %h", out_product, want));
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // at reset shift of 32 fraction bits
    queue_pair('0, '0);
    queue_pair(MAX_S, MAX_S);
    queue_pair(MIN_S, MIN_S);
    queue_pair(MIN_S, MAX_S);
    queue_pair(MAX_S, MIN_S);
    queue_pair(MIN_S, ALL_ONE);
    queue_pair(ALL_ONE, MIN_S);
    queue_pair(ALL_ONE, ALL_ONE);
    queue_pair(64'd1, 64'd1);
    queue_pair(ONE_Q32, ONE_Q32);
    queue_pair(ONE_Q32, -ONE_Q32);
    queue_pair(-ONE_Q32, 64'h0000_0001_8000_0000);
    queue_pair(ALL_ONE, 64'd1);
    queue_pair(-64'sd3, 64'h0000_0000_8000_0000);
    queue_pair(64'd3, -64'h0000_0000_8000_0000);
    queue_pair(ALT_A, ALT_5);
    queue_pair(ALT_5, ALT_A);
    queue_pair(MAX_S, 64'd1);
    queue_pair(MIN_S, 64'd1);
    queue_pair('0, MIN_S);

    run_phase(130, 7'd0, 1'b1);
    run_phase(130, 7'd127, 1'b1);
    run_phase(130, 7'd64, 1'b1);
    run_phase(130, 7'd63, 1'b0);
    run_phase(130, 7'd1, 1'b1);
    run_phase(130, 7'd31, 1'b1);
    repeat (3) run_phase(130, 7'($urandom_range(0, 127)), 1'b1);
    run_phase(130, 7'd32, 1'b0);

    wait_drained();
    repeat (12) @(negedge clk);
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
